### rtl/sla_pkg.sv
// Shared constants and types for the script line assembler.
package sla_pkg;

	localparam int LINE_CAPACITY = 512;
	localparam int LENGTH_BITS   = 16;

	localparam int CAP_NARROW = LINE_CAPACITY;
	localparam int CAP_WIDE   = (LINE_CAPACITY / 2 > 0) ? LINE_CAPACITY / 2 : 1;
	localparam int SLOT_W     = $clog2(LINE_CAPACITY);
	localparam int CMP_W      = (LENGTH_BITS > 14) ? LENGTH_BITS : 14;

	localparam int UNIT_W   = 16;
	localparam int SLOT_OUT = 9;
	localparam int LINE_W   = 16;

	// character codes
	localparam logic [UNIT_W-1:0] CH_SEMI  = 16'h003B;
	localparam logic [UNIT_W-1:0] CH_QUOTE = 16'h0022;
	localparam logic [UNIT_W-1:0] CH_CR    = 16'h000D;
	localparam logic [UNIT_W-1:0] CH_LF    = 16'h000A;
	localparam logic [UNIT_W-1:0] CH_TAB   = 16'h0009;
	localparam logic [UNIT_W-1:0] CH_SPACE = 16'h0020;

	// result kinds
	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_EOL  = 1'b1;

	// comment mode codes
	localparam logic [1:0] CM_SCAN    = 2'd0;
	localparam logic [1:0] CM_BLANK   = 2'd1;
	localparam logic [1:0] CM_CONTENT = 2'd2;

	typedef struct packed {
		logic                kind;
		logic [UNIT_W-1:0]   unit_out;
		logic [SLOT_OUT-1:0] slot;
		logic [15:0]         line_length;
		logic [LINE_W-1:0]   line_number;
		logic                length_overflow;
	} result_t;

endpackage

### rtl/script_line_assembler.sv
// Script line assembler: one code unit in, at most one kept unit or line end out.
//
// Takes one code unit per cycle while in_stall is low: each unit is decoded
// combinationally against a few flags and the line counters, and the result
// lands in an output register. A one-entry skid register behind it
// lets the block keep accepting while a result waits; in_stall rises only when
// both the output register and the skid entry are occupied. The wide_mode
// register is written through cfg_valid/cfg_ready, which always accepts, and
// should only be written while no request is in flight.
module script_line_assembler (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          wide_mode,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [sla_pkg::UNIT_W-1:0]    code_unit,
	input  logic                          end_of_input,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          kind,
	output logic [sla_pkg::UNIT_W-1:0]    unit_out,
	output logic [sla_pkg::SLOT_OUT-1:0]  slot,
	output logic [15:0]                   line_length,
	output logic [sla_pkg::LINE_W-1:0]    line_number,
	output logic                          length_overflow
);
	import sla_pkg::*;

	localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

	logic                   wide_q;
	logic                   quoted_q, has_content_q, swallow_q;
	logic [LENGTH_BITS-1:0] length_q;
	logic [SLOT_W-1:0]      slot_n_q, slot_w_q;
	logic [LINE_W-1:0]      line_q;
	logic [1:0]             comment_mode_q;

	logic    out_valid_q, skid_valid_q;
	result_t out_q, skid_q;

	logic              in_acc, out_take;
	logic              eoi, skip;
	logic [UNIT_W-1:0] c;
	logic              is_cr, is_lf, is_zero, is_term;

	logic       do_keep, do_end, do_restart, restart_pre, bump_line;
	logic       toggle_quote, set_content;
	logic [1:0] cm_next;

	logic [SLOT_W-1:0]      slot_cur, slot_n_inc, slot_w_inc;
	logic [CMP_W-1:0]       cap_cmp, len_cmp;
	logic                   len_at_max, len_ovf;
	logic [LENGTH_BITS-1:0] len_inc;
	logic [LINE_W-1:0]      line_base;
	logic                   r_valid;
	result_t                r;

	assign cfg_ready = 1'b1;
	assign in_stall  = skid_valid_q;
	assign in_acc    = in_valid && !skid_valid_q;
	assign out_take  = out_valid_q && !out_stall;

	always_comb begin
		eoi     = end_of_input;
		c       = wide_q ? code_unit : {8'h00, code_unit[7:0]};
		if (eoi) begin
			c = '0;
		end
		skip    = swallow_q && !eoi;
		is_cr   = (c == CH_CR);
		is_lf   = (c == CH_LF);
		is_zero = (c == '0);
		is_term = is_cr || is_lf || is_zero;
	end

	// per-unit decision
	always_comb begin
		do_keep      = 1'b0;
		do_end       = 1'b0;
		do_restart   = 1'b0;
		restart_pre  = 1'b0;
		bump_line    = 1'b0;
		toggle_quote = 1'b0;
		set_content  = 1'b0;
		cm_next      = comment_mode_q;
		if (!skip) begin
			unique case (comment_mode_q)
				CM_BLANK: begin
					if (is_term) begin
						// end of text restarts the line, then closes an empty one
						if (eoi) begin
							restart_pre = 1'b1;
							do_end      = 1'b1;
						end else begin
							do_restart = 1'b1;
						end
					end
				end
				CM_CONTENT: begin
					if (is_term) begin
						do_end = 1'b1;
					end
				end
				default: begin
					priority if (is_cr || is_lf) begin
						if (has_content_q) begin
							do_end = 1'b1;
						end else begin
							bump_line = 1'b1;
						end
					end else if (is_zero) begin
						do_end = 1'b1;
					end else if (c == CH_QUOTE) begin
						toggle_quote = 1'b1;
						set_content  = 1'b1;
						do_keep      = 1'b1;
					end else if (c == CH_SEMI && !quoted_q) begin
						cm_next = has_content_q ? CM_CONTENT : CM_BLANK;
					end else begin
						set_content = (c != CH_TAB) && (c != CH_SPACE);
						do_keep     = 1'b1;
					end
				end
			endcase
		end
	end

	// result fields
	always_comb begin
		slot_cur   = wide_q ? slot_w_q : slot_n_q;
		slot_n_inc = (slot_n_q == SLOT_W'(CAP_NARROW - 1)) ? '0 : slot_n_q + 1'b1;
		slot_w_inc = (slot_w_q == SLOT_W'(CAP_WIDE - 1)) ? '0 : slot_w_q + 1'b1;
		cap_cmp    = wide_q ? CMP_W'(CAP_WIDE) : CMP_W'(CAP_NARROW);
		len_cmp    = CMP_W'(length_q);
		len_at_max = (length_q == LEN_MAX);
		len_ovf    = (len_cmp >= cap_cmp) || len_at_max;
		len_inc    = len_at_max ? length_q : length_q + 1'b1;
		line_base  = restart_pre ? line_q + 1'b1 : line_q;

		r_valid           = in_acc && (do_keep || do_end);
		r.line_number     = line_base;
		r.slot            = restart_pre ? '0 : SLOT_OUT'(slot_cur);
		r.length_overflow = restart_pre ? 1'b0 : len_ovf;
		if (do_end) begin
			r.kind        = KIND_EOL;
			r.unit_out    = '0;
			r.line_length = restart_pre ? '0 : 16'(length_q);
		end else begin
			r.kind        = KIND_CHAR;
			r.unit_out    = c;
			r.line_length = 16'(len_inc);
		end
	end

	// line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_q         <= 1'b0;
			quoted_q       <= 1'b0;
			has_content_q  <= 1'b0;
			swallow_q      <= 1'b0;
			length_q       <= '0;
			slot_n_q       <= '0;
			slot_w_q       <= '0;
			line_q         <= '0;
			comment_mode_q <= CM_SCAN;
		end else begin
			if (cfg_valid && cfg_ready) begin
				wide_q <= wide_mode;
			end
			if (in_acc) begin
				swallow_q <= !skip && is_cr;
				if (do_end || do_restart) begin
					quoted_q       <= 1'b0;
					has_content_q  <= 1'b0;
					length_q       <= '0;
					slot_n_q       <= '0;
					slot_w_q       <= '0;
					comment_mode_q <= CM_SCAN;
					line_q         <= line_base + 1'b1;
				end else if (bump_line) begin
					line_q <= line_q + 1'b1;
				end else begin
					comment_mode_q <= cm_next;
					quoted_q       <= quoted_q ^ toggle_quote;
					has_content_q  <= has_content_q || set_content;
					if (do_keep && !len_at_max) begin
						length_q <= len_inc;
						slot_n_q <= slot_n_inc;
						slot_w_q <= slot_w_inc;
					end
				end
			end
		end
	end

	// output register with one skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || out_take) begin
				out_valid_q  <= skid_valid_q || r_valid;
				skid_valid_q <= 1'b0;
			end else if (r_valid) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_take) begin
			out_q <= skid_valid_q ? skid_q : r;
		end
		if (r_valid && out_valid_q && !out_take) begin
			skid_q <= r;
		end
	end

	assign out_valid       = out_valid_q;
	assign kind            = out_q.kind;
	assign unit_out        = out_q.unit_out;
	assign slot            = out_q.slot;
	assign line_length     = out_q.line_length;
	assign line_number     = out_q.line_number;
	assign length_overflow = out_q.length_overflow;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held while output register empty");

	a_swallow_scan: assert property (@(posedge clk) disable iff (!arst_n)
		swallow_q |-> (comment_mode_q == CM_SCAN))
		else $error("swallow pending inside a comment");

	a_quote_content: assert property (@(posedge clk) disable iff (!arst_n)
		quoted_q |-> has_content_q)
		else $error("quoted line without content");

	a_slot_track: assert property (@(posedge clk) disable iff (!arst_n)
		(length_q == '0) |-> (slot_n_q == '0 && slot_w_q == '0))
		else $error("slot counters out of step with length");

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (do_end || do_restart)) |=> (length_q == '0 && !quoted_q))
		else $error("line state not cleared at line end");

endmodule

### tb/sv/script_line_assembler_test.sv
// Self-checking testbench for the script line assembler: predicts each result and checks in order.
module script_line_assembler_test;
	timeunit 1ns;
	timeprecision 1ps;
	import sla_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_ITEMS = 750;
	localparam int PHASES       = 6;
	localparam longint unsigned LEN_MAX = (64'd1 << LENGTH_BITS) - 1;

	// Line state tracker: mirrors the block and keeps the results still owed by it.
	class line_tracker;
		result_t pending[$];
		bit wide;
		bit quoted, has_content, swallow;
		longint unsigned length_count;
		bit [15:0] line_ctr;
		bit [1:0] cmode;
		int mismatches, checked, line_ends;

		function longint unsigned capacity();
			return wide ? CAP_WIDE : CAP_NARROW;
		endfunction

		function void push(logic k, logic [15:0] u, longint unsigned pos,
			longint unsigned len);
			result_t r;
			longint unsigned cap;
			cap = capacity();
			r.kind = k;
			r.unit_out = u;
			r.slot = SLOT_OUT'(pos % cap);
			r.line_length = 16'(len);
			r.line_number = line_ctr;
			r.length_overflow = (pos >= cap || pos >= LEN_MAX);
			pending.push_back(r);
		endfunction

		function void keep(logic [15:0] c);
			longint unsigned old;
			old = length_count;
			if (old < LEN_MAX)
				length_count++;
			push(KIND_CHAR, c, old, length_count);
		endfunction

		function void restart();
			length_count = 0;
			has_content = 0;
			quoted = 0;
			cmode = CM_SCAN;
			line_ctr++;
		endfunction

		function void end_line();
			push(KIND_EOL, 16'h0000, length_count, length_count);
			restart();
		endfunction

		function void note_unit(logic [15:0] unit, logic eoi);
			logic [15:0] c;
			c = wide ? unit : {8'h00, unit[7:0]};
			if (eoi)
				c = 16'h0000;
			if (swallow) begin
				swallow = 0;
				if (!eoi)
					return;
			end
			if (cmode == CM_BLANK || cmode == CM_CONTENT) begin
				if (c == CH_CR)
					swallow = 1;
				if (c == CH_CR || c == CH_LF || c == 16'h0000) begin
					if (cmode == CM_CONTENT) begin
						end_line();
					end else begin
						restart();
						// everything after end of input reads as zero: empty line end
						if (eoi)
							end_line();
					end
				end
				return;
			end
			if (c == CH_CR || c == CH_LF) begin
				if (c == CH_CR)
					swallow = 1;
				if (!has_content)
					line_ctr++;
				else
					end_line();
				return;
			end
			if (c == 16'h0000) begin
				end_line();
				return;
			end
			if (c == CH_QUOTE) begin
				quoted = !quoted;
				has_content = 1;
				keep(c);
				return;
			end
			if (c == CH_SEMI && !quoted) begin
				cmode = has_content ? CM_CONTENT : CM_BLANK;
				return;
			end
			if (c != CH_TAB && c != CH_SPACE)
				has_content = 1;
			keep(c);
		endfunction

		function void check_output(result_t got);
			result_t exp;
			checked++;
			if (got.kind == KIND_EOL)
				line_ends++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: kind %0d unit %h slot %0d len %0d line %0d ovf %0d",
						got.kind, got.unit_out, got.slot, got.line_length,
						got.line_number, got.length_overflow);
				return;
			end
			exp = pending.pop_front();
			if (got.kind !== exp.kind || got.unit_out !== exp.unit_out ||
				got.slot !== exp.slot || got.line_length !== exp.line_length ||
				got.line_number !== exp.line_number ||
				got.length_overflow !== exp.length_overflow) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch exp: kind %0d unit %h slot %0d len %0d line %0d ovf %0d",
						exp.kind, exp.unit_out, exp.slot, exp.line_length,
						exp.line_number, exp.length_overflow);
					$display("         got: kind %0d unit %h slot %0d len %0d line %0d ovf %0d",
						got.kind, got.unit_out, got.slot, got.line_length,
						got.line_number, got.length_overflow);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic wide_wr = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [UNIT_W-1:0] code_unit = '0;
	logic end_of_input = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic kind;
	logic [UNIT_W-1:0] unit_out;
	logic [SLOT_OUT-1:0] slot;
	logic [15:0] line_length;
	logic [LINE_W-1:0] line_number;
	logic length_overflow;

	line_tracker tracker = new();
	bit quiet = 1'b0;
	int stall_left = 0;
	int cycles = 0;
	int items_sent = 0;
	int mode_writes = 0;

	script_line_assembler dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.wide_mode(wide_wr),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.code_unit(code_unit),
		.end_of_input(end_of_input),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.unit_out(unit_out),
		.slot(slot),
		.line_length(line_length),
		.line_number(line_number),
		.length_overflow(length_overflow)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	// output side: check each accepted result, then stall a random while
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			tracker.check_output({kind, unit_out, slot, line_length, line_number,
				length_overflow});
			stall_left = quiet ? 0 : $urandom_range(0, 9);
		end
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic send_unit(input logic [15:0] u, input logic e);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		code_unit <= u;
		end_of_input <= e;
		do @(posedge clk); while (in_stall);
		tracker.note_unit(u, e);
		items_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (tracker.pending.size() != 0)
			@(posedge clk);
		// a request that makes no result may still be in the pipe
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input bit v);
		drain();
		cfg_valid <= 1'b1;
		wide_wr <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		tracker.wide = v;
		mode_writes++;
	endtask

	function automatic logic [15:0] random_char();
		int r;
		logic [7:0] hi;
		r = $urandom_range(0, 99);
		hi = tracker.wide ? 8'h00 : 8'($urandom);
		if (r < 50)
			return {hi, 8'($urandom_range(8'h61, 8'h7A))};
		else if (r < 62)
			return {hi, CH_SPACE[7:0]};
		else if (r < 70)
			return {hi, CH_TAB[7:0]};
		else if (r < 78)
			return {hi, CH_QUOTE[7:0]};
		else if (r < 83)
			return {hi, CH_SEMI[7:0]};
		else if (r < 90)
			return 16'($urandom);
		return {hi, 8'($urandom_range(8'h30, 8'h39))};
	endfunction

	task automatic random_line();
		int n, r;
		n = $urandom_range(0, 12);
		if ($urandom_range(0, 99) < 3)
			n = $urandom_range(260, 300);
		repeat (n) send_unit(random_char(), 1'b0);
		r = $urandom_range(0, 99);
		if (r < 40) begin
			send_unit(CH_LF, 1'b0);
		end else if (r < 60) begin
			send_unit(CH_CR, 1'b0);
			send_unit(CH_LF, 1'b0);
		end else if (r < 70) begin
			send_unit(CH_CR, 1'b0);
			send_unit(random_char(), 1'b0);
		end else if (r < 78) begin
			send_unit(CH_SEMI, 1'b0);
			repeat ($urandom_range(0, 6)) send_unit(random_char(), 1'b0);
			send_unit(CH_LF, 1'b0);
		end else if (r < 84) begin
			send_unit(16'h0000, 1'b0);
		end else if (r < 88) begin
			send_unit(16'($urandom), 1'b1);
		end else if (r < 92) begin
			send_unit(CH_CR, 1'b0);
			send_unit(16'($urandom), 1'b1);
		end
	endtask

	initial begin
		int target;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_mode(1'b0);
		// narrow: high byte ignored, quoted semicolon kept, content comment ends line
		send_unit(16'h0061, 1'b0);
		send_unit(16'hFFFF, 1'b0);
		send_unit(CH_QUOTE, 1'b0);
		send_unit(CH_SEMI, 1'b0);
		send_unit(CH_QUOTE, 1'b0);
		send_unit(CH_SEMI, 1'b0);
		send_unit(16'h007A, 1'b0);
		send_unit(CH_LF, 1'b0);
		// whitespace-only newline only bumps the line number
		send_unit(CH_SPACE, 1'b0);
		send_unit(CH_TAB, 1'b0);
		send_unit(CH_LF, 1'b0);
		send_unit(16'h0071, 1'b0);
		send_unit(16'h0000, 1'b0);
		// blank-line comment dropped by a zero unit, then end of input right after a CR
		send_unit(CH_SEMI, 1'b0);
		send_unit(16'h0078, 1'b0);
		send_unit(16'h0000, 1'b0);
		send_unit(16'h006D, 1'b0);
		send_unit(CH_CR, 1'b0);
		send_unit(16'h005A, 1'b1);
		// end of input inside a blank-line comment
		send_unit(CH_SEMI, 1'b0);
		send_unit(16'h0041, 1'b1);

		write_mode(1'b1);
		send_unit(16'hFFFF, 1'b0);
		send_unit(16'h013B, 1'b0);
		send_unit(16'h0000, 1'b0);
		send_unit(CH_CR, 1'b0);
		send_unit(CH_LF, 1'b0);

		for (int p = 0; p < PHASES; p++) begin
			write_mode(p == 0 || p == 2 || p == 3);
			quiet = (p == 4);
			target = items_sent + RANDOM_ITEMS / PHASES;
			while (items_sent < target)
				random_line();
		end

		// long line past the narrow capacity, so the slot wraps
		quiet = 1'b1;
		write_mode(1'b0);
		repeat (530) send_unit(16'h0061, 1'b0);
		send_unit(CH_LF, 1'b0);
		send_unit(16'h0062, 1'b1);
		quiet = 1'b0;

		drain();
		$display("Sent %0d code units across %0d mode writes (narrow and wide).",
			items_sent, mode_writes);
		$display("Checked %0d results including %0d line ends.",
			tracker.checked, tracker.line_ends);
		if (tracker.mismatches + tracker.pending.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

### filelist.f
rtl/sla_pkg.sv
rtl/script_line_assembler.sv
tb/sv/script_line_assembler_test.sv
